// ===== rtl/core/ktrt_pkg.sv =====
package ktrt_pkg;
   localparam int SLOTS = 32;
   localparam int MAX_REQUESTED = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] OP_RESERVE = 3'd0;
   localparam logic [2:0] OP_PEEK    = 3'd1;
   localparam logic [2:0] OP_PUBLISH = 3'd2;
   localparam logic [2:0] OP_SETTLE  = 3'd3;
   localparam logic [2:0] OP_CANCEL  = 3'd4;
   localparam logic [2:0] OP_RESET   = 3'd5;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] session_key;
      logic [63:0] host_generation;
      logic [63:0] binding_generation;
      logic [31:0] command_number;
      logic [31:0] wave_number;
      logic [31:0] spawner_number;
      logic [7:0]  request_count;
      logic [63:0] ticket_number;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] ticket_out;
      logic        published_out;
      logic [31:0] command_out;
      logic [31:0] wave_out;
      logic [31:0] spawner_out;
      logic [7:0]  count_out;
   } rsp_type;

   typedef struct packed {
      logic             load;
      logic             scan_start;
      logic             scan_step;
      logic [IDX_W-1:0] scan_index;
      logic             finish;
   } cmd_type;

   typedef struct packed {
      logic stop_early;
   } status_type;
endpackage

// ===== rtl/core/keyed_ticket_reservation_table.sv =====
// Reservation table of 32 slots keyed by session, host and binding generation.
// Each transaction scans the slots one per cycle through a single compare unit.
// After a request is accepted, the scan is started, the slots are visited in order
// and the response is then registered. A reserve, publish or settle stops the scan
// early once it finds its slot, and an invalid reserve or a zero ticket stops at the
// first slot.
// Peek and cancel always visit every slot. One transaction is in flight at a
// time, and the next is accepted in the cycle after the response has been taken.
module keyed_ticket_reservation_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, session_key, host_generation, binding_generation, command_number,
   // wave_number, spawner_number, request_count, ticket_number; zero pad
   input  logic [367:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ok, ticket_out, published_out, command_out, wave_out, spawner_out,
   // count_out; zero pad
   output logic [175:0] rsp_tdata
);
   import ktrt_pkg::*;

   req_type    req;
   rsp_type    rsp;
   cmd_type    cmd;
   status_type status;

   assign req.opcode             = req_tdata[2:0];
   assign req.session_key        = req_tdata[66:3];
   assign req.host_generation    = req_tdata[130:67];
   assign req.binding_generation = req_tdata[194:131];
   assign req.command_number     = req_tdata[226:195];
   assign req.wave_number        = req_tdata[258:227];
   assign req.spawner_number     = req_tdata[290:259];
   assign req.request_count      = req_tdata[298:291];
   assign req.ticket_number      = req_tdata[362:299];

   assign rsp_tdata = {6'd0, rsp.count_out, rsp.spawner_out, rsp.wave_out,
                       rsp.command_out, rsp.published_out, rsp.ticket_out, rsp.ok};

   ktrt_control u_control (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .status(status), .cmd(cmd)
   );

   ktrt_datapath u_datapath (
      .clock(clock), .reset(reset), .req_in(req), .cmd(cmd), .status(status),
      .rsp_out(rsp)
   );
endmodule

// ===== rtl/core/ktrt_datapath.sv =====
module ktrt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ktrt_pkg::req_type    req_in,
   input  ktrt_pkg::cmd_type    cmd,
   output ktrt_pkg::status_type status,
   output ktrt_pkg::rsp_type    rsp_out
);
   import ktrt_pkg::*;

   logic [63:0] mem_session [SLOTS];
   logic [63:0] mem_host [SLOTS];
   logic [63:0] mem_bind [SLOTS];
   logic [31:0] mem_command [SLOTS];
   logic [31:0] mem_wave [SLOTS];
   logic [31:0] mem_spawner [SLOTS];
   logic [7:0]  mem_count [SLOTS];
   logic [63:0] mem_ticket [SLOTS];
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] pub_ff, pub_in;
   logic [63:0] next_ticket_ff, next_ticket_in;

   req_type     req_ff;
   logic        found_ff, found_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic        free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic        done_ff, done_in;
   rsp_type     rsp_ff, rsp_in;

   logic [IDX_W-1:0] ix;
   logic        v, p, key_hit, fields_ok;
   logic        write_slot;
   logic [63:0] tk_i;

   assign ix = cmd.scan_index;
   assign v = valid_ff[ix];
   assign p = pub_ff[ix];
   assign tk_i = mem_ticket[ix];
   assign key_hit = v && mem_session[ix] == req_ff.session_key
                    && mem_host[ix] == req_ff.host_generation
                    && mem_bind[ix] == req_ff.binding_generation;
   assign fields_ok = req_ff.session_key != '0 && req_ff.host_generation != '0
                      && req_ff.binding_generation != '0 && req_ff.command_number != '0
                      && req_ff.wave_number != '0 && req_ff.spawner_number != '0
                      && req_ff.request_count != '0
                      && req_ff.request_count <= 8'(MAX_REQUESTED);
   assign status.stop_early = done_ff;
   assign rsp_out = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      pub_in = pub_ff;
      next_ticket_in = next_ticket_ff;
      found_in = found_ff;
      sel_in = sel_ff;
      free_found_in = free_found_ff;
      free_in = free_ff;
      done_in = done_ff;
      rsp_in = rsp_ff;
      write_slot = 1'b0;
      if (cmd.scan_start) begin
         found_in = 1'b0;
         free_found_in = 1'b0;
         done_in = 1'b0;
      end else if (cmd.scan_step && !done_ff) begin
         unique case (req_ff.opcode)
            OP_RESERVE: begin
               if (!fields_ok) begin
                  done_in = 1'b1;
               end else if (key_hit && mem_command[ix] == req_ff.command_number) begin
                  found_in = 1'b1;
                  sel_in = ix;
                  done_in = 1'b1;
               end else if (!v && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in = ix;
               end
            end
            OP_PEEK: begin
               if (key_hit && (!found_ff || tk_i < mem_ticket[sel_ff])) begin
                  found_in = 1'b1;
                  sel_in = ix;
               end
            end
            OP_PUBLISH, OP_SETTLE: begin
               if (req_ff.ticket_number == '0) begin
                  done_in = 1'b1;
               end else if (v && tk_i == req_ff.ticket_number
                            && (req_ff.opcode == OP_PUBLISH || p)) begin
                  found_in = 1'b1;
                  sel_in = ix;
                  done_in = 1'b1;
                  if (req_ff.opcode == OP_PUBLISH) begin
                     pub_in[ix] = 1'b1;
                  end else begin
                     valid_in[ix] = 1'b0;
                     pub_in[ix] = 1'b0;
                  end
               end
            end
            OP_CANCEL: begin
               if (key_hit) begin
                  valid_in[ix] = 1'b0;
                  pub_in[ix] = 1'b0;
               end
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end
      if (cmd.finish) begin
         rsp_in = '0;
         unique case (req_ff.opcode)
            OP_RESERVE: begin
               if (fields_ok && found_ff) begin
                  rsp_in.ok = 1'b1;
                  rsp_in.ticket_out = mem_ticket[sel_ff];
               end else if (fields_ok && free_found_ff && next_ticket_ff != '1) begin
                  write_slot = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  pub_in[free_ff] = 1'b0;
                  next_ticket_in = next_ticket_ff + 64'd1;
                  rsp_in.ok = 1'b1;
                  rsp_in.ticket_out = next_ticket_ff;
               end
            end
            OP_PEEK: begin
               if (found_ff) begin
                  rsp_in.ok = 1'b1;
                  rsp_in.ticket_out = mem_ticket[sel_ff];
                  rsp_in.published_out = pub_ff[sel_ff];
                  rsp_in.command_out = mem_command[sel_ff];
                  rsp_in.wave_out = mem_wave[sel_ff];
                  rsp_in.spawner_out = mem_spawner[sel_ff];
                  rsp_in.count_out = mem_count[sel_ff];
               end
            end
            OP_PUBLISH, OP_SETTLE: begin
               if (found_ff) begin
                  rsp_in.ok = 1'b1;
                  rsp_in.ticket_out = req_ff.ticket_number;
               end
            end
            OP_CANCEL: rsp_in.ok = 1'b1;
            OP_RESET: begin
               rsp_in.ok = 1'b1;
               valid_in = '0;
               pub_in = '0;
               next_ticket_in = 64'd1;
            end
            default: rsp_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pub_ff <= '0;
         next_ticket_ff <= 64'd1;
         done_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pub_ff <= pub_in;
         next_ticket_ff <= next_ticket_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
      end
      found_ff <= found_in;
      sel_ff <= sel_in;
      free_found_ff <= free_found_in;
      free_ff <= free_in;
      rsp_ff <= rsp_in;
      if (write_slot) begin
         mem_session[free_ff] <= req_ff.session_key;
         mem_host[free_ff] <= req_ff.host_generation;
         mem_bind[free_ff] <= req_ff.binding_generation;
         mem_command[free_ff] <= req_ff.command_number;
         mem_wave[free_ff] <= req_ff.wave_number;
         mem_spawner[free_ff] <= req_ff.spawner_number;
         mem_count[free_ff] <= req_ff.request_count;
         mem_ticket[free_ff] <= next_ticket_ff;
      end
   end
endmodule

// ===== rtl/core/ktrt_control.sv =====
module ktrt_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ktrt_pkg::status_type status,
   output ktrt_pkg::cmd_type    cmd
);
   import ktrt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             out_ff, out_in;
   logic             accept;

   assign req_tready = state_ff == ST_IDLE && !out_ff;
   assign rsp_tvalid = out_ff;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      out_in = out_ff && !rsp_tready;
      cmd = '0;
      cmd.scan_index = count_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = count_ff != '0;
            if (count_ff == '0) begin
               cmd.scan_start = 1'b1;
               count_in = CNT_W'(1);
            end else begin
               cmd.scan_index = IDX_W'(count_ff - CNT_W'(1));
               if (count_ff == CNT_W'(SLOTS) || status.stop_early) begin
                  state_in = ST_DONE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            out_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_ff <= out_in;
      end
   end
endmodule

// ===== rtl/core/ktrt_checker.sv =====
module ktrt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata
);
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
   a_no_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_fail_zero_ticket: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[64:1] == 64'd0)
      else $error("ticket on failure");
endmodule

bind keyed_ticket_reservation_table ktrt_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
